/* rtl/ckct_pkg.sv */
// ----------------------------------------------------------------------------
// ckct_pkg
// Shared types and constants for the coordinate-keyed cell table.
// ----------------------------------------------------------------------------
package ckct_pkg;

   localparam int CellsDefault   = 64;
   localparam int BucketsDefault = 64;
   localparam int SlotOutWidth   = 6;
   localparam int VersionWidth   = 32;
   localparam int HashWidth      = 32;
   localparam int CoordElems     = 9;

   localparam logic [1:0] REQ_LOOKUP    = 2'd0;
   localparam logic [1:0] REQ_ALLOCATE  = 2'd1;
   localparam logic [1:0] REQ_SET_CLASS = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PRESENT   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [2:0] CLASS_VIRTUAL = 3'd0;
   localparam logic [2:0] CLASS_PINNED  = 3'd1;
   localparam logic [2:0] CLASS_SYSTEM  = 3'd2;
   localparam logic [2:0] CLASS_PURPOSE = 3'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [63:0]       coord_first_eight;
      logic signed [7:0] coord_last;
      logic              pinned_request;
      logic [2:0]        new_class;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [31:0] version;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_BUCKET,
      S_SCAN,
      S_EVICT,
      S_DONE
   } state_type;

   // Command sent into the cell chain for one scan step.
   typedef struct packed {
      logic        active;
      logic        evict;
      logic [63:0] low;
      logic [7:0]  high;
   } chain_cmd_type;

   // One hash step: h*3 + (e + 1), element sign-extended, wrapped to 32 bits.
   function automatic logic [HashWidth-1:0] hash_step(input logic [HashWidth-1:0] h,
                                                      input logic [7:0] e);
      logic [HashWidth-1:0] ext;
      ext = {{(HashWidth-8){e[7]}}, e};
      return (h << 1) + h + ext + 32'd1;
   endfunction

   function automatic logic class_locked(input logic [2:0] cls);
      return cls == CLASS_PINNED || cls == CLASS_SYSTEM || cls == CLASS_PURPOSE;
   endfunction

endpackage

/* rtl/ckct_cell.sv */
// ----------------------------------------------------------------------------
// ckct_cell
// One table cell: holds a coordinate and class, compares the coordinate
// with the search key, and reports a match and whether it may be evicted.
// ----------------------------------------------------------------------------
module ckct_cell (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [63:0] wr_low,
   input  logic [7:0] wr_high,
   input  logic [2:0] wr_class,
   input  logic [63:0] key_low,
   input  logic [7:0] key_high,
   output logic       match,
   output logic       evictable
);

   logic [63:0] low_ff;
   logic [7:0]  high_ff;
   logic [2:0]  class_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         low_ff   <= wr_low;
         high_ff  <= wr_high;
         class_ff <= wr_class;
      end
   end

   assign match     = (low_ff == key_low) && (high_ff == key_high);
   assign evictable = !ckct_pkg::class_locked(class_ff);

endmodule

/* rtl/ckct_chain.sv */
// ----------------------------------------------------------------------------
// ckct_chain
// The row of cells. The search key is broadcast to every cell; the scan
// position selects one cell a cycle and reports its match and evictable flag.
// ----------------------------------------------------------------------------
module ckct_chain #(
   parameter int CELLS = ckct_pkg::CellsDefault,
   parameter int SW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_slot,
   input  logic [63:0]   wr_low,
   input  logic [7:0]    wr_high,
   input  logic [2:0]    wr_class,
   input  logic [63:0]   key_low,
   input  logic [7:0]    key_high,
   input  logic [SW-1:0] probe_slot,
   output logic          probe_match,
   output logic          probe_evictable
);

   logic [CELLS-1:0] match_w;
   logic [CELLS-1:0] evict_w;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      ckct_cell u_cell (
         .clock     (clock),
         .wr_en     (wr_en && (wr_slot == SW'(i))),
         .wr_low    (wr_low),
         .wr_high   (wr_high),
         .wr_class  (wr_class),
         .key_low   (key_low),
         .key_high  (key_high),
         .match     (match_w[i]),
         .evictable (evict_w[i])
      );
   end

   assign probe_match     = match_w[probe_slot];
   assign probe_evictable = evict_w[probe_slot];

endmodule

/* rtl/coord_keyed_cell_table_evict.sv */
// ----------------------------------------------------------------------------
// coord_keyed_cell_table_evict
// Table of cells keyed by a nine-byte coordinate, with round-robin eviction.
// ----------------------------------------------------------------------------
// Usage: raise start with req_item while busy is low; the item is taken at
// that edge and busy rises. One result appears on rsp_item for exactly one
// cycle, marked by rsp_strobe; the receiver cannot stall it.
// The nine coordinate elements are hashed in turn, then the bucket table
// is given the address and its registered read data is checked. A bucket
// hit then probes the bucket's slot and forms the result, which is
// registered onto rsp_strobe. A miss scans the used slots one per cycle,
// and an eviction scans up to CELLS slots from the eviction pointer before
// reporting a full table. busy stays high through the strobe cycle, so the
// next item is taken in the cycle after it at the earliest. One item is in
// flight at a time.
// The bucket table is a memory read and written at one address with a
// registered read; each bucket carries a valid bit cleared by reset.
// Reset (synchronous) empties the table, clears the eviction pointer and
// sets the version to one. Cell contents are not cleared; only used slots
// are ever compared.
// ----------------------------------------------------------------------------
module coord_keyed_cell_table_evict #(
   parameter int CELLS   = ckct_pkg::CellsDefault,
   parameter int BUCKETS = ckct_pkg::BucketsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ckct_pkg::req_item_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output ckct_pkg::rsp_item_type rsp_item
);

   localparam int SW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW = $clog2(CELLS + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   ckct_pkg::state_type state_ff, state_in;
   ckct_pkg::req_item_type req_ff, req_in;
   logic [31:0]  hash_ff, hash_in;
   logic [3:0]   step_ff, step_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] used_ff, used_in;
   logic [SW-1:0] evp_ff, evp_in;
   logic [31:0]  ver_ff, ver_in;
   logic         rsp_ff, rsp_in;
   ckct_pkg::rsp_item_type out_ff, out_in;
   logic         bprobe_ff, bprobe_in;

   logic [SW-1:0]  bucket_mem [BUCKETS];
   logic [BUCKETS-1:0] bvalid_ff;
   logic [SW-1:0]  bslot_ff;
   logic           bvld_rd_ff;
   logic [BW-1:0]  bidx;
   logic           bwr_en;
   logic [SW-1:0]  bwr_slot;

   logic          wr_en;
   logic [SW-1:0] wr_slot;
   logic [2:0]    wr_class;
   logic [SW-1:0] probe_slot;
   logic          probe_match, probe_evictable;
   logic [7:0]    elem;

   ckct_chain #(.CELLS(CELLS), .SW(SW)) u_chain (
      .clock           (clock),
      .wr_en           (wr_en),
      .wr_slot         (wr_slot),
      .wr_low          (req_ff.coord_first_eight),
      .wr_high         (req_ff.coord_last),
      .wr_class        (wr_class),
      .key_low         (req_ff.coord_first_eight),
      .key_high        (req_ff.coord_last),
      .probe_slot      (probe_slot),
      .probe_match     (probe_match),
      .probe_evictable (probe_evictable)
   );

   assign bidx = BW'(hash_ff % BUCKETS);

   always_ff @(posedge clock) begin
      bslot_ff   <= bucket_mem[bidx];
      bvld_rd_ff <= bvalid_ff[bidx];
      if (bwr_en) begin
         bucket_mem[bidx] <= bwr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
      end else if (bwr_en) begin
         bvalid_ff[bidx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckct_pkg::S_IDLE;
         used_ff  <= '0;
         evp_ff   <= '0;
         ver_ff   <= 32'd1;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         evp_ff   <= evp_in;
         ver_ff   <= ver_in;
         rsp_ff   <= rsp_in;
      end
      req_ff    <= req_in;
      hash_ff   <= hash_in;
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      out_ff    <= out_in;
      bprobe_ff <= bprobe_in;
   end

   always_comb begin
      elem = (step_ff == 4'd8) ? req_ff.coord_last
                               : req_ff.coord_first_eight[step_ff[2:0]*8 +: 8];
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      hash_in   = hash_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      evp_in    = evp_ff;
      ver_in    = ver_ff;
      rsp_in    = 1'b0;
      out_in    = out_ff;
      bprobe_in = bprobe_ff;
      wr_en     = 1'b0;
      wr_slot   = pos_ff;
      wr_class  = req_ff.new_class;
      bwr_en    = 1'b0;
      bwr_slot  = pos_ff;
      probe_slot = pos_ff;
      case (state_ff)
         ckct_pkg::S_IDLE: begin
            if (start && !busy) begin
               req_in   = req_item;
               hash_in  = '0;
               step_in  = '0;
               state_in = ckct_pkg::S_HASH;
            end
         end
         ckct_pkg::S_HASH: begin
            hash_in = ckct_pkg::hash_step(hash_ff, elem);
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) begin
               bprobe_in = 1'b0;
               state_in  = ckct_pkg::S_BUCKET;
            end
         end
         ckct_pkg::S_BUCKET: begin
            // Bucket read data arrives in the cycle after the address.
            if (!bprobe_ff) begin
               bprobe_in = 1'b1;
            end else begin
               pos_in = bslot_ff;
               cnt_in = '0;
               if (bvld_rd_ff && (CW'(bslot_ff) < used_ff)) begin
                  state_in = ckct_pkg::S_SCAN;
                  step_in  = 4'd1;
               end else begin
                  pos_in   = '0;
                  step_in  = 4'd0;
                  state_in = ckct_pkg::S_SCAN;
               end
            end
         end
         ckct_pkg::S_SCAN: begin
            // step 1: single bucket probe; step 0: linear scan.
            if (step_ff == 4'd1 && probe_match) begin
               state_in = ckct_pkg::S_DONE;
            end else if (step_ff == 4'd1) begin
               pos_in  = '0;
               step_in = 4'd0;
            end else if (CW'(pos_ff) >= used_ff || (cnt_ff == CW'(CELLS))) begin
               state_in = ckct_pkg::S_DONE;
               step_in  = 4'd2;
            end else if (probe_match) begin
               state_in = ckct_pkg::S_DONE;
            end else begin
               pos_in = (CW'(pos_ff) == CW'(CELLS - 1)) ? '0 : pos_ff + SW'(1);
               cnt_in = cnt_ff + CW'(1);
               if (CW'(pos_ff) == CW'(CELLS - 1)) begin
                  state_in = ckct_pkg::S_DONE;
                  step_in  = 4'd2;
               end
            end
         end
         ckct_pkg::S_EVICT: begin
            if (cnt_ff == CW'(CELLS)) begin
               out_in   = '{status: ckct_pkg::ST_FULL, slot: '0, version: ver_ff};
               rsp_in   = 1'b1;
               state_in = ckct_pkg::S_IDLE;
            end else if (probe_evictable) begin
               wr_en    = 1'b1;
               wr_class = req_ff.pinned_request ? ckct_pkg::CLASS_PINNED
                                                : ckct_pkg::CLASS_VIRTUAL;
               bwr_en   = 1'b1;
               evp_in   = (CW'(pos_ff) == CW'(CELLS - 1)) ? '0 : pos_ff + SW'(1);
               ver_in   = ver_ff + 32'd1;
               out_in   = '{status: ckct_pkg::ST_OK, slot: 6'(pos_ff),
                            version: ver_ff + 32'd1};
               rsp_in   = 1'b1;
               state_in = ckct_pkg::S_IDLE;
            end else begin
               pos_in = (CW'(pos_ff) == CW'(CELLS - 1)) ? '0 : pos_ff + SW'(1);
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ckct_pkg::S_DONE: begin
            rsp_in   = 1'b1;
            state_in = ckct_pkg::S_IDLE;
            if (step_ff != 4'd2) begin
               // Found at pos_ff.
               case (req_ff.req_type)
                  ckct_pkg::REQ_ALLOCATE: begin
                     out_in = '{status: ckct_pkg::ST_PRESENT, slot: 6'(pos_ff),
                                version: ver_ff};
                  end
                  ckct_pkg::REQ_SET_CLASS: begin
                     wr_en  = 1'b1;
                     out_in = '{status: ckct_pkg::ST_OK, slot: 6'(pos_ff),
                                version: ver_ff};
                  end
                  default: begin
                     out_in = '{status: ckct_pkg::ST_OK, slot: 6'(pos_ff),
                                version: ver_ff};
                  end
               endcase
               if (req_ff.req_type == ckct_pkg::REQ_SET_CLASS) begin
                  wr_class = req_ff.new_class;
               end
            end else if (req_ff.req_type == ckct_pkg::REQ_ALLOCATE) begin
               if (used_ff < CW'(CELLS)) begin
                  wr_en    = 1'b1;
                  wr_slot  = SW'(used_ff);
                  wr_class = req_ff.pinned_request ? ckct_pkg::CLASS_PINNED
                                                   : ckct_pkg::CLASS_VIRTUAL;
                  bwr_en   = 1'b1;
                  bwr_slot = SW'(used_ff);
                  used_in  = used_ff + CW'(1);
                  ver_in   = ver_ff + 32'd1;
                  out_in   = '{status: ckct_pkg::ST_OK, slot: 6'(used_ff),
                               version: ver_ff + 32'd1};
               end else begin
                  rsp_in   = 1'b0;
                  pos_in   = evp_ff;
                  cnt_in   = '0;
                  state_in = ckct_pkg::S_EVICT;
               end
            end else begin
               out_in = '{status: ckct_pkg::ST_NOT_FOUND, slot: '0, version: ver_ff};
            end
         end
         default: begin
            state_in = ckct_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ckct_pkg::S_IDLE) || rsp_ff;
   assign rsp_strobe = rsp_ff;
   assign rsp_item   = out_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(CELLS)) else $error("used count above cell count");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held two cycles");

   a_version_step: assert property (@(posedge clock) disable iff (reset)
      (ver_ff != $past(ver_ff)) |-> (ver_ff == $past(ver_ff) + 32'd1))
      else $error("version moved by more than one");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result without busy");

endmodule

/* test/tb_coord_keyed_cell_table_evict.sv */
// ----------------------------------------------------------------------------
// tb_coord_keyed_cell_table_evict
// Self-checking testbench for the coordinate-keyed cell table. A clocked
// driver sends items from a queue in random bursts, a clocked monitor takes
// each strobed result, and a predictor of the table computes the expected
// status, slot and version for every accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coord_keyed_cell_table_evict;
   import ckct_pkg::*;

   localparam int NumCells   = 64;
   localparam int NumBuckets = 64;

   logic         clock;
   logic         reset;
   logic         start;
   req_item_type req_item;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   coord_keyed_cell_table_evict #(.CELLS(NumCells), .BUCKETS(NumBuckets)) dut (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // Predictor state.
   logic [63:0] cell_low [NumCells];
   logic [7:0]  cell_high [NumCells];
   logic [2:0]  cell_class [NumCells];
   logic [5:0]  bucket_slot [NumBuckets];
   logic        bucket_live [NumBuckets];
   int          cells_used;
   int          evict_at;
   logic [31:0] table_version;

   req_item_type pending_items[$];
   rsp_item_type expected_results[$];
   int           mismatch_count;
   int           burst_left;
   int           gap_left;
   bit           feeding_done;

   // Known coordinates, reused to hit present entries.
   logic [71:0]  known_coords[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int coord_bucket(logic [63:0] low, logic [7:0] high);
      logic [31:0] h;
      logic [7:0]  e;
      h = 32'd0;
      for (int i = 0; i < 9; i++) begin
         e = (i < 8) ? low[8*i +: 8] : high;
         h = h * 32'd3 + {{24{e[7]}}, e} + 32'd1;
      end
      return int'(h % NumBuckets);
   endfunction

   function automatic int locate_coord(logic [63:0] low, logic [7:0] high);
      int b;
      b = coord_bucket(low, high);
      if (bucket_live[b] && int'(bucket_slot[b]) < cells_used
          && cell_low[bucket_slot[b]] == low && cell_high[bucket_slot[b]] == high)
         return int'(bucket_slot[b]);
      for (int s = 0; s < cells_used; s++)
         if (cell_low[s] == low && cell_high[s] == high) return s;
      return -1;
   endfunction

   function automatic rsp_item_type predict_table(req_item_type it);
      rsp_item_type r;
      int s;
      int t;
      logic [63:0] low;
      logic [7:0] high;
      low = it.coord_first_eight;
      high = it.coord_last;
      r.status = ST_NOT_FOUND;
      r.slot = '0;
      s = locate_coord(low, high);
      if (it.req_type == REQ_ALLOCATE) begin
         if (s >= 0) begin
            r.status = ST_PRESENT;
            r.slot = s[5:0];
         end else begin
            if (cells_used < NumCells) begin
               s = cells_used;
               cells_used++;
            end else begin
               for (int i = 0; i < NumCells; i++) begin
                  t = (evict_at + i) % NumCells;
                  if (s < 0 && !(cell_class[t] inside {CLASS_PINNED, CLASS_SYSTEM,
                                                     CLASS_PURPOSE})) begin
                     s = t;
                     evict_at = (t + 1) % NumCells;
                  end
               end
            end
            if (s >= 0) begin
               cell_low[s] = low;
               cell_high[s] = high;
               cell_class[s] = it.pinned_request ? CLASS_PINNED : CLASS_VIRTUAL;
               bucket_slot[coord_bucket(low, high)] = s[5:0];
               bucket_live[coord_bucket(low, high)] = 1'b1;
               table_version++;
               r.status = ST_OK;
               r.slot = s[5:0];
            end else begin
               r.status = ST_FULL;
            end
         end
      end else if (it.req_type == REQ_SET_CLASS) begin
         if (s >= 0) begin
            cell_class[s] = it.new_class;
            r.status = ST_OK;
            r.slot = s[5:0];
         end
      end else if (s >= 0) begin
         r.status = ST_OK;
         r.slot = s[5:0];
      end
      r.version = table_version;
      return r;
   endfunction

   function automatic req_item_type make_item(logic [1:0] kind, logic [71:0] c,
                                              logic pin, logic [2:0] cls);
      req_item_type it;
      it.req_type = kind;
      it.coord_first_eight = c[63:0];
      it.coord_last = c[71:64];
      it.pinned_request = pin;
      it.new_class = cls;
      return it;
   endfunction

   function automatic logic [71:0] fresh_coord();
      logic [71:0] c;
      c = 72'({$urandom, $urandom, $urandom});
      // Mostly small coordinates, which share buckets often.
      if ($urandom_range(0, 2) != 0)
         for (int i = 0; i < 9; i++) c[8*i +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
      return c;
   endfunction

   function automatic logic [71:0] pick_coord();
      if (known_coords.size() > 0 && $urandom_range(0, 3) != 0)
         return known_coords[$urandom_range(0, known_coords.size() - 1)];
      return fresh_coord();
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (start && !busy) begin
         expected_results.push_back(predict_table(req_item));
         pending_items.pop_front();
         if (burst_left > 0 && pending_items.size() > 0) begin
            req_item <= pending_items[0];
            burst_left <= burst_left - 1;
         end else begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items[0];
            start <= 1'b1;
            burst_left <= $urandom_range(0, 12);
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d slot %0d version %0d",
                        rsp_item.status, rsp_item.slot, rsp_item.version);
         end else begin
            if (rsp_item !== expected_results[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d slot %0d version %0d, got %0d %0d %0d",
                           expected_results[0].status, expected_results[0].slot,
                           expected_results[0].version, rsp_item.status,
                           rsp_item.slot, rsp_item.version);
            end
            expected_results.pop_front();
         end
      end
   end

   initial begin
      logic [71:0] c;
      logic [1:0]  kind;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      mismatch_count = 0;
      feeding_done = 1'b0;
      cells_used = 0;
      evict_at = 0;
      table_version = 32'd1;
      for (int i = 0; i < NumBuckets; i++) begin
         bucket_live[i] = 1'b0;
         bucket_slot[i] = '0;
      end
      for (int i = 0; i < NumCells; i++) begin
         cell_low[i] = '0;
         cell_high[i] = '0;
         cell_class[i] = '0;
      end

      // Directed: misses on an empty table, extreme coordinates, duplicates,
      // set class on a missing cell, and the unused request type.
      pending_items.push_back(make_item(REQ_LOOKUP, '0, 1'b0, 3'd0));
      pending_items.push_back(make_item(REQ_SET_CLASS, '1, 1'b0, 3'd4));
      pending_items.push_back(make_item(REQ_ALLOCATE, '0, 1'b0, 3'd0));
      pending_items.push_back(make_item(REQ_ALLOCATE, '1, 1'b1, 3'd7));
      pending_items.push_back(make_item(REQ_ALLOCATE, {8'h80, {8{8'h80}}}, 1'b0, 3'd0));
      pending_items.push_back(make_item(REQ_ALLOCATE, {8'h7f, {8{8'h7f}}}, 1'b1, 3'd0));
      pending_items.push_back(make_item(REQ_ALLOCATE, '0, 1'b1, 3'd0));
      pending_items.push_back(make_item(REQ_LOOKUP, '1, 1'b0, 3'd0));
      pending_items.push_back(make_item(2'd3, {8'h7f, {8{8'h7f}}}, 1'b0, 3'd0));
      pending_items.push_back(make_item(REQ_SET_CLASS, '0, 1'b0, 3'd7));
      pending_items.push_back(make_item(REQ_SET_CLASS, '1, 1'b1, 3'd2));
      pending_items.push_back(make_item(REQ_LOOKUP, {8'h80, {8{8'h80}}}, 1'b0, 3'd0));
      known_coords = '{'0, '1, {8'h80, {8{8'h80}}}, {8'h7f, {8{8'h7f}}}};

      // Fill and pin everything, then allocate once more: table full.
      for (int i = 0; i < 70; i++) begin
         c = fresh_coord();
         known_coords.push_back(c);
         pending_items.push_back(make_item(REQ_ALLOCATE, c, 1'b1, 3'd0));
      end
      for (int i = 0; i < known_coords.size(); i++)
         pending_items.push_back(make_item(REQ_SET_CLASS, known_coords[i], 1'b0,
                                           3'($urandom_range(1, 3))));
      pending_items.push_back(make_item(REQ_ALLOCATE, fresh_coord(), 1'b0, 3'd0));

      // Random operations on a full table: class changes reopen eviction.
      for (int i = 0; i < 300; i++) begin
         c = pick_coord();
         kind = 2'($urandom_range(0, 9) < 4 ? 1 : $urandom_range(0, 3));
         if (kind == REQ_ALLOCATE && known_coords.size() < 400) known_coords.push_back(c);
         pending_items.push_back(make_item(kind, c, 1'($urandom), 3'($urandom)));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("tb_coord_keyed_cell_table_evict: done, clean");
      else
         $display("tb_coord_keyed_cell_table_evict: done, errors");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_coord_keyed_cell_table_evict: done, errors");
      $finish;
   end

endmodule
